@@ rtl/core/ilp_pkg.sv @@
// Shared types and character codes for the integer literal parser.
`default_nettype none

package ilp_pkg;

    // Result width in bits
    localparam int VALUE_WIDTH = 32;

    // UTF-16 code units the parser recognizes
    localparam logic [15:0] CH_ZERO  = 16'h0030;
    localparam logic [15:0] CH_NINE  = 16'h0039;
    localparam logic [15:0] CH_LO_A  = 16'h0061;
    localparam logic [15:0] CH_LO_F  = 16'h0066;
    localparam logic [15:0] CH_UP_A  = 16'h0041;
    localparam logic [15:0] CH_UP_F  = 16'h0046;
    localparam logic [15:0] CH_LO_X  = 16'h0078;
    localparam logic [15:0] CH_UP_X  = 16'h0058;
    localparam logic [15:0] CH_MINUS = 16'h002D;

    // One character request
    typedef struct packed {
        logic [15:0] char_code;
        logic        last;
        logic        no_char;
    } t_char_req;

    // One parse result
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   parse_error;
    } t_result_req;

    // Digit unit answer: digit valid and in range, and the new magnitude
    typedef struct packed {
        logic                   ok;
        logic [VALUE_WIDTH-1:0] acc;
    } t_digit_res;

endpackage

`default_nettype wire

@@ rtl/core/integer_literal_parser_core.sv @@
// Top level of the integer literal parser: input stage, parse state, result register.
//
// Usage: characters of a literal arrive one per request on the input channel
// (valid/ready). A leading 0x/0X selects hex, a leading minus selects negative
// decimal. The request marked last yields one result request on the output
// channel carrying the value and the parse_error flag; other requests yield
// nothing. A request with no_char set carries no character (ends an empty
// literal when also last). i_cfg_we/i_cfg_data set the unsigned type; write
// it only between literals while no result is pending.
// Flow: a last request passes from the input register into the result register
// when processed. Throughput: one request per cycle while no result stalls the
// output; the per-character step is one shift-add multiply by the base plus a
// limit compare between the input register and the state/result registers.
// Stall: while a result waits on the output, the input register holds and
// ready drops only once that register is also full.
// Reset: synchronous, active low; clears the type to signed, the parse state
// to start of literal and both channels to empty.
`default_nettype none

module integer_literal_parser_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ilp_pkg::t_char_req   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output ilp_pkg::t_result_req      o_out
);

    localparam int W = ilp_pkg::VALUE_WIDTH;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ZERO  = 2'd1,
        PH_BODY  = 2'd2
    } t_phase;

    logic                 r_cfg_unsigned;
    logic                 r_s1_valid;
    ilp_pkg::t_char_req   r_s1;
    t_phase               r_phase, n_phase;
    logic                 r_hex, n_hex;
    logic                 r_neg, n_neg;
    logic [W-1:0]         r_acc, n_acc;
    logic                 r_err, n_err;
    logic                 r_out_valid;
    ilp_pkg::t_result_req r_out, n_out;

    logic                 stall;
    logic                 fire;
    ilp_pkg::t_digit_res  dig;

    assign stall       = r_out_valid && !i_out_ready;
    assign fire        = r_s1_valid && !stall;
    assign o_in_ready  = !r_s1_valid || !stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    ilp_digit u_digit (
        .i_char_code     (r_s1.char_code),
        .i_hex_mode      (r_hex),
        .i_neg_mode      (r_neg),
        .i_unsigned_type (r_cfg_unsigned),
        .i_acc           (r_acc),
        .o_res           (dig)
    );

    // Step the parse state for the request in the input register
    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_err   = r_err;
        n_out   = r_out;
        if (!r_s1.no_char && !r_err) begin
            unique case (r_phase)
                PH_START: begin
                    n_phase = PH_BODY;
                    if (r_s1.char_code == ilp_pkg::CH_MINUS) begin
                        n_neg = 1'b1;
                    end else if (r_s1.char_code == ilp_pkg::CH_ZERO) begin
                        n_phase = PH_ZERO;
                    end else begin
                        n_err = !dig.ok;
                        n_acc = dig.ok ? dig.acc : r_acc;
                    end
                end
                PH_ZERO: begin
                    n_phase = PH_BODY;
                    if (r_s1.char_code == ilp_pkg::CH_LO_X
                        || r_s1.char_code == ilp_pkg::CH_UP_X) begin
                        n_hex = 1'b1;
                    end else begin
                        n_err = !dig.ok;
                        n_acc = dig.ok ? dig.acc : r_acc;
                    end
                end
                default: begin
                    n_err = !dig.ok;
                    n_acc = dig.ok ? dig.acc : r_acc;
                end
            endcase
        end
        // Build the result, then clear for the next literal
        if (r_s1.last) begin
            if (n_phase == PH_START) begin
                n_err = 1'b1;
            end
            n_out.parse_error = n_err;
            if (n_err) begin
                n_out.value = '0;
            end else begin
                n_out.value = n_neg ? (W'(0) - n_acc) : n_acc;
            end
            n_phase = PH_START;
            n_hex   = 1'b0;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_err   = 1'b0;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_unsigned <= 1'b0;
        end else if (i_cfg_we) begin
            r_cfg_unsigned <= i_cfg_data;
        end
    end

    // Input register: load on accept, drain when processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in;
        end
    end

    // Parse state: advance on each processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_hex   <= 1'b0;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_err   <= 1'b0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_err   <= n_err;
        end
    end

    // Result register: load on a last request, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_s1.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_s1.last) begin
            r_out <= n_out;
        end
    end

    // An error result always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.parse_error) |-> (r_out.value == '0))
        else $error("error result with nonzero value");

    // A last request leaves the parse state cleared
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_s1.last) |=> (r_phase == PH_START && r_acc == '0 && !r_err
                                 && !r_hex && !r_neg))
        else $error("parse state not cleared after last request");

    // Signed positive magnitude stays below the sign bit
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_cfg_unsigned && !r_neg) |-> !r_acc[W-1])
        else $error("signed positive magnitude out of range");

    // Negative unsigned literal only accumulates zeros
    a_neg_unsigned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cfg_unsigned && r_neg) |-> (r_acc == '0))
        else $error("negative unsigned magnitude not zero");

endmodule

`default_nettype wire

@@ rtl/core/ilp_digit.sv @@
// Digit decode and range-checked multiply-accumulate for the literal parser.
`default_nettype none

module ilp_digit (
    input  wire logic [15:0]                     i_char_code,
    input  wire logic                            i_hex_mode,
    input  wire logic                            i_neg_mode,
    input  wire logic                            i_unsigned_type,
    input  wire logic [ilp_pkg::VALUE_WIDTH-1:0] i_acc,
    output ilp_pkg::t_digit_res                  o_res
);

    localparam int W   = ilp_pkg::VALUE_WIDTH;
    localparam int EXT = W + 5;

    localparam logic [EXT-1:0] SIGN_MAG = EXT'(1) << (W - 1);
    localparam logic [EXT-1:0] VMASK    = (EXT'(1) << W) - EXT'(1);

    logic           is_dec;
    logic           is_lo;
    logic           is_up;
    logic           is_digit;
    logic [3:0]     digit;
    logic [EXT-1:0] acc_ext;
    logic [EXT-1:0] prod;
    logic [EXT-1:0] sum;
    logic [EXT-1:0] limit;

    // Classify the character and pick its digit value
    always_comb begin
        is_dec   = (i_char_code >= ilp_pkg::CH_ZERO) && (i_char_code <= ilp_pkg::CH_NINE);
        is_lo    = i_hex_mode && (i_char_code >= ilp_pkg::CH_LO_A)
                   && (i_char_code <= ilp_pkg::CH_LO_F);
        is_up    = i_hex_mode && (i_char_code >= ilp_pkg::CH_UP_A)
                   && (i_char_code <= ilp_pkg::CH_UP_F);
        is_digit = is_dec || is_lo || is_up;
        digit    = is_dec ? i_char_code[3:0] : (i_char_code[3:0] + 4'd9);
    end

    // Largest magnitude allowed in this direction
    always_comb begin
        if (i_neg_mode) begin
            limit = i_unsigned_type ? '0 : SIGN_MAG;
        end else begin
            limit = i_unsigned_type ? VMASK : (SIGN_MAG - EXT'(1));
        end
    end

    // Shift-add multiply by the base, add the digit, check the limit
    always_comb begin
        acc_ext   = EXT'(i_acc);
        prod      = i_hex_mode ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
        sum       = prod + EXT'(digit);
        o_res.ok  = is_digit && (sum <= limit);
        o_res.acc = sum[W-1:0];
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the integer literal parser core.
module testbench;

    localparam int          RANDOM_ITEMS  = 1800;
    localparam int          TYPE_EVERY    = 150;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam logic [15:0] CH_TOP        = 16'hFFFF;
    localparam logic [63:0] VAL_MASK      = (64'd1 << ilp_pkg::VALUE_WIDTH) - 64'd1;
    localparam logic [63:0] SIGN_BIT      = 64'd1 << (ilp_pkg::VALUE_WIDTH - 1);

    typedef enum logic [1:0] {LIT_START, LIT_ZERO, LIT_BODY} t_lit_phase;
    typedef enum logic {ROW_CHAR, ROW_TYPE} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        ilp_pkg::t_char_req   req;
        logic                 typed;
        ilp_pkg::t_result_req want;
        logic                 type_val;
    } t_stim_row;

    logic                 i_clk      = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic                 cfg_data   = 1'b0;
    logic                 in_valid   = 1'b0;
    ilp_pkg::t_char_req   char_bus   = '0;
    logic                 out_ready  = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    ilp_pkg::t_result_req o_out;

    // parser shadow state
    t_lit_phase  lit_phase     = LIT_START;
    logic        lit_hex       = 1'b0;
    logic        lit_neg       = 1'b0;
    logic [63:0] lit_mag       = '0;
    logic        lit_bad       = 1'b0;
    logic        type_unsigned = 1'b0;

    ilp_pkg::t_result_req pending_results[$];
    t_stim_row            stim_rows[$];
    ilp_pkg::t_char_req   literal_reqs[$];

    int          fail_count  = 0;
    int          cycle_count = 0;
    int unsigned snd_gap_pct = 0;
    int unsigned rcv_gap_pct = 0;
    logic        hold_req    = 1'b0;
    int          stall_left  = 0;

    integer_literal_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (char_bus),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Fold one digit into the magnitude, flag bad digits and range overflow
    function automatic void fold_digit(logic [15:0] c);
        logic [63:0] base;
        logic [63:0] d;
        logic [63:0] lim;
        base = lit_hex ? 64'd16 : 64'd10;
        if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE) begin
            d = c - ilp_pkg::CH_ZERO;
        end else if (lit_hex && c >= ilp_pkg::CH_LO_A && c <= ilp_pkg::CH_LO_F) begin
            d = c - ilp_pkg::CH_LO_A + 64'd10;
        end else if (lit_hex && c >= ilp_pkg::CH_UP_A && c <= ilp_pkg::CH_UP_F) begin
            d = c - ilp_pkg::CH_UP_A + 64'd10;
        end else begin
            lit_bad = 1'b1;
            return;
        end
        if (lit_neg) begin
            lim = type_unsigned ? 64'd0 : SIGN_BIT;
        end else begin
            lim = type_unsigned ? VAL_MASK : SIGN_BIT - 64'd1;
        end
        if (d > lim || lit_mag > (lim - d) / base) begin
            lit_bad = 1'b1;
            return;
        end
        lit_mag = lit_mag * base + d;
    endfunction

    // Advance the literal state by one character
    function automatic void absorb_char(logic [15:0] c);
        if (lit_bad) begin
            return;
        end
        case (lit_phase)
            LIT_START: begin
                if (c == ilp_pkg::CH_MINUS) begin
                    lit_neg = 1'b1;
                end else if (c != ilp_pkg::CH_ZERO) begin
                    fold_digit(c);
                end
                lit_phase = (c == ilp_pkg::CH_ZERO) ? LIT_ZERO : LIT_BODY;
            end
            LIT_ZERO: begin
                if (c == ilp_pkg::CH_LO_X || c == ilp_pkg::CH_UP_X) begin
                    lit_hex = 1'b1;
                end else begin
                    fold_digit(c);
                end
                lit_phase = LIT_BODY;
            end
            default: fold_digit(c);
        endcase
    endfunction

    // Apply one request; produce the parse result when it closes the literal
    function automatic void step_parser(ilp_pkg::t_char_req req,
                                        output ilp_pkg::t_result_req res,
                                        output logic gives);
        res   = '0;
        gives = 1'b0;
        if (!req.no_char) begin
            absorb_char(req.char_code);
        end
        if (req.last) begin
            if (lit_phase == LIT_START) begin
                lit_bad = 1'b1;
            end
            if (lit_bad) begin
                res.value = '0;
            end else if (lit_neg) begin
                res.value = ilp_pkg::VALUE_WIDTH'((64'd0 - lit_mag) & VAL_MASK);
            end else begin
                res.value = ilp_pkg::VALUE_WIDTH'(lit_mag & VAL_MASK);
            end
            res.parse_error = lit_bad;
            gives     = 1'b1;
            lit_phase = LIT_START;
            lit_hex   = 1'b0;
            lit_neg   = 1'b0;
            lit_mag   = '0;
            lit_bad   = 1'b0;
        end
    endfunction

    // Offer one request, wait for the handshake, then record its result
    task automatic send_req(ilp_pkg::t_char_req req, logic typed,
                            ilp_pkg::t_result_req want);
        ilp_pkg::t_result_req got;
        logic                 gives;
        while ($urandom_range(99) < snd_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        char_bus <= req;
        do @(posedge i_clk); while (!o_in_ready);
        step_parser(req, got, gives);
        if (gives) begin
            pending_results.push_back(typed ? want : got);
        end
    endtask

    // Hold the input until every result is back and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the type register while the block is idle
    task automatic set_type(logic u);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= u;
        @(posedge i_clk);
        cfg_we        <= 1'b0;
        type_unsigned = u;
    endtask

    task automatic add_char_row(logic [15:0] ch, logic last, logic none, logic typed,
                                logic [ilp_pkg::VALUE_WIDTH-1:0] val, logic err);
        t_stim_row r;
        r.kind             = ROW_CHAR;
        r.req.char_code    = ch;
        r.req.last         = last;
        r.req.no_char      = none;
        r.typed            = typed;
        r.want.value       = val;
        r.want.parse_error = err;
        r.type_val         = 1'b0;
        stim_rows.push_back(r);
    endtask

    task automatic add_type_row(logic u);
        t_stim_row r;
        r.kind     = ROW_TYPE;
        r.req      = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        r.type_val = u;
        stim_rows.push_back(r);
    endtask

    // Directed literals: special cases and extremes
    task automatic build_directed_table();
        add_type_row(1'b0);
        // empty literal
        add_char_row(ilp_pkg::CH_ZERO, 1'b1, 1'b1, 1'b1, '0, 1'b1);
        // bare minus and bare hex prefix
        add_char_row(ilp_pkg::CH_MINUS, 1'b1, 1'b0, 1'b1, '0, 1'b0);
        add_char_row(ilp_pkg::CH_ZERO, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_UP_X, 1'b1, 1'b0, 1'b1, '0, 1'b0);
        // blank request mid-literal is ignored, then a bad decimal digit
        add_char_row(ilp_pkg::CH_NINE, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(CH_TOP, 1'b0, 1'b1, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_UP_X, 1'b1, 1'b0, 1'b1, '0, 1'b1);
        // hex with mixed case digits
        add_char_row(ilp_pkg::CH_ZERO, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_LO_X, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_UP_F, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_LO_A, 1'b1, 1'b0, 1'b0, '0, 1'b0);
        // negative decimal
        add_char_row(ilp_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_ZERO + 16'd8, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFF8, 1'b0);
        // top code unit is a bad digit
        add_char_row(CH_TOP, 1'b1, 1'b0, 1'b1, '0, 1'b1);
        // signed hex above the signed maximum overflows
        add_char_row(ilp_pkg::CH_ZERO, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_LO_X, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_ZERO + 16'd8, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        repeat (6) add_char_row(ilp_pkg::CH_ZERO, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_ZERO, 1'b1, 1'b0, 1'b1, '0, 1'b1);
        // unsigned type: negative zero passes, negative nonzero underflows
        add_type_row(1'b1);
        add_char_row(ilp_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_ZERO, 1'b1, 1'b0, 1'b1, '0, 1'b0);
        add_char_row(ilp_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_char_row(ilp_pkg::CH_ZERO + 16'd1, 1'b1, 1'b0, 1'b1, '0, 1'b1);
    endtask

    // Build one random literal: mostly well formed, some noise and damage
    task automatic build_literal();
        int unsigned        pick;
        int unsigned        style;
        int unsigned        pos;
        logic [63:0]        mag;
        logic [63:0]        base;
        logic [4:0]         digs[$];
        ilp_pkg::t_char_req r;
        literal_reqs.delete();
        r    = '0;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // noise characters
            repeat ($urandom_range(1, 6)) begin
                r.char_code = $urandom_range(1) ? 16'($urandom_range(16'hFFFF))
                                                : 16'($urandom_range(16'h20, 16'h7E));
                literal_reqs.push_back(r);
            end
        end else if (pick < 12) begin
            // empty literal, maybe after some blank requests
            r.no_char = 1'b1;
            repeat ($urandom_range(0, 2)) literal_reqs.push_back(r);
        end else begin
            style = $urandom_range(2);
            base  = (style == 2) ? 64'd16 : 64'd10;
            pick  = $urandom_range(9);
            if (pick < 4) begin
                mag = $urandom_range(999);
            end else if (pick < 7) begin
                mag = {$urandom, $urandom} >> $urandom_range(31, 63);
            end else begin
                case ($urandom_range(4))
                    0:       mag = 64'h7FFF_FFFF;
                    1:       mag = 64'h8000_0000;
                    2:       mag = 64'hFFFF_FFFF;
                    3:       mag = 64'h1_0000_0000;
                    default: mag = 64'd2;
                endcase
                mag = mag + $urandom_range(4) - 64'd2;
            end
            do begin
                digs.push_front(5'(mag % base));
                mag = mag / base;
            end while (mag != 0);
            if (style != 0 && $urandom_range(11) == 0) begin
                digs.delete();
            end else if ($urandom_range(6) == 0) begin
                repeat ($urandom_range(1, 2)) digs.push_front(5'd0);
            end
            // prefix
            if (style == 1) begin
                r.char_code = ilp_pkg::CH_MINUS;
                literal_reqs.push_back(r);
            end else if (style == 2) begin
                r.char_code = ilp_pkg::CH_ZERO;
                literal_reqs.push_back(r);
                r.char_code = $urandom_range(1) ? ilp_pkg::CH_LO_X : ilp_pkg::CH_UP_X;
                literal_reqs.push_back(r);
            end
            foreach (digs[i]) begin
                if (digs[i] < 10) begin
                    r.char_code = ilp_pkg::CH_ZERO + 16'(digs[i]);
                end else begin
                    r.char_code = ($urandom_range(1) ? ilp_pkg::CH_LO_A : ilp_pkg::CH_UP_A)
                                  + 16'(digs[i] - 10);
                end
                literal_reqs.push_back(r);
            end
            // damage one character
            if (literal_reqs.size() != 0 && $urandom_range(11) == 0) begin
                pos = $urandom_range(literal_reqs.size() - 1);
                literal_reqs[pos].char_code = 16'($urandom_range(16'hFFFF));
            end
            // slip in a blank request
            if ($urandom_range(11) == 0) begin
                r.char_code = 16'($urandom_range(16'hFFFF));
                r.no_char   = 1'b1;
                literal_reqs.insert($urandom_range(literal_reqs.size()), r);
            end
        end
        // close with the last character or a blank last request
        if (literal_reqs.size() == 0 || literal_reqs[literal_reqs.size() - 1].no_char
                || $urandom_range(4) == 0) begin
            r.char_code = 16'($urandom_range(16'hFFFF));
            r.no_char   = 1'b1;
            r.last      = 1'b1;
            literal_reqs.push_back(r);
        end else begin
            literal_reqs[literal_reqs.size() - 1].last = 1'b1;
        end
    endtask

    // Check results against the oldest expectation; pick next ready
    always @(posedge i_clk) begin
        ilp_pkg::t_result_req want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: value %h parse_error %b",
                       o_out.value, o_out.parse_error);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, o_out.value);
                    fail_count++;
                end
                if (o_out.parse_error !== want.parse_error) begin
                    $error("parse_error: expected %b, got %b",
                           want.parse_error, o_out.parse_error);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_gap_pct);
        end
    end

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // Main stimulus
    initial begin
        int sent;
        int since_type;
        build_directed_table();
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        snd_gap_pct = 18;
        rcv_gap_pct = 79;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_TYPE) begin
                set_type(stim_rows[i].type_val);
            end else begin
                send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
            end
        end
        since_type = 0;
        for (int idle_mode = 0; idle_mode < 3; idle_mode++) begin
            snd_gap_pct = (idle_mode == 0) ? 18 : (idle_mode == 1) ? 79 : 0;
            rcv_gap_pct = (idle_mode == 0) ? 79 : (idle_mode == 1) ? 18 : 0;
            // stall the output for a long stretch while requests keep coming
            if (idle_mode == 2) begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                if (since_type >= TYPE_EVERY) begin
                    set_type(!type_unsigned);
                    since_type = 0;
                end
                build_literal();
                foreach (literal_reqs[i]) begin
                    send_req(literal_reqs[i], 1'b0, '0);
                    if (!literal_reqs[i].no_char || literal_reqs[i].last) begin
                        sent++;
                        since_type++;
                    end
                end
            end
        end
        settle();
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
